// ----- rtl/dq_pkg.sv -----
// ----------------------------------------------------------------------------
// dq_pkg
// Shared widths and codes for the bounded double-ended queue.
// ----------------------------------------------------------------------------
package dq_pkg;

  localparam int REQ_W = 3;
  localparam int VAL_W = 32;
  localparam int ST_W  = 2;
  localparam int OCC_W = 6;

  // request codes
  localparam logic [REQ_W-1:0] REQ_PUSH_FRONT = 3'd0;
  localparam logic [REQ_W-1:0] REQ_PUSH_BACK  = 3'd1;
  localparam logic [REQ_W-1:0] REQ_POP_FRONT  = 3'd2;
  localparam logic [REQ_W-1:0] REQ_POP_BACK   = 3'd3;
  localparam logic [REQ_W-1:0] REQ_LIST       = 3'd4;

  // result status codes
  localparam logic [ST_W-1:0] ST_DONE  = 2'd0;
  localparam logic [ST_W-1:0] ST_FULL  = 2'd1;
  localparam logic [ST_W-1:0] ST_EMPTY = 2'd2;

endpackage

// ----- rtl/double_ended_queue.sv -----
// ----------------------------------------------------------------------------
// double_ended_queue
// Bounded deque of signed 32-bit values kept as a ring in one memory.
// ----------------------------------------------------------------------------
//  channel   handshake            payload
//  request   start & !busy        req_type, push_value
//  result    strobe (one cycle)   item_value, last_of_run, status, occupancy
//
//  Push, rejected push, empty pop and empty list: result in the cycle after
//  accept, busy stays low. Pop: read data passes the memory's read register,
//  then the result register. List: one item per cycle through the read port.
//  Reset clears front index and count; memory contents are not cleared.
//  Results cannot be stalled; busy holds off requests during a read run.
// ----------------------------------------------------------------------------
module double_ended_queue import dq_pkg::*; #(
  parameter int DEPTH = 32
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  output logic                    busy,
  input  logic [REQ_W-1:0]        req_type,
  input  logic signed [VAL_W-1:0] push_value,
  output logic                    strobe,
  output logic signed [VAL_W-1:0] item_value,
  output logic                    last_of_run,
  output logic [ST_W-1:0]         status,
  output logic [OCC_W-1:0]        occupancy
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic             wr_en;
  logic [AW-1:0]    wr_addr;
  logic [VAL_W-1:0] wr_data;
  logic             rd_en;
  logic [AW-1:0]    rd_addr;
  logic [VAL_W-1:0] rd_data;

  dq_ctrl #(.DEPTH(DEPTH)) u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .req_type    (req_type),
    .push_value  (push_value),
    .mem_wr_en   (wr_en),
    .mem_wr_addr (wr_addr),
    .mem_wr_data (wr_data),
    .mem_rd_en   (rd_en),
    .mem_rd_addr (rd_addr),
    .mem_rd_data (rd_data),
    .strobe      (strobe),
    .item_value  (item_value),
    .last_of_run (last_of_run),
    .status      (status),
    .occupancy   (occupancy)
  );

  dq_ram #(.DEPTH(DEPTH)) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // a push always answers in the next cycle with a single item
  a_push_result: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && (req_type == REQ_PUSH_FRONT || req_type == REQ_PUSH_BACK))
      |=> (strobe && last_of_run && !busy))
    else $error("push did not produce a single result");

  // an unknown request produces nothing
  a_unknown_silent: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && req_type != REQ_PUSH_FRONT && req_type != REQ_PUSH_BACK &&
     req_type != REQ_POP_FRONT && req_type != REQ_POP_BACK && req_type != REQ_LIST)
      |=> (!strobe && !busy))
    else $error("unknown request produced activity");

  // a run that is not finished keeps the block busy
  a_run_busy: assert property (@(posedge clk) disable iff (rst)
    (strobe && !last_of_run) |-> busy)
    else $error("list run ended without its last item");

  // a rejected push is only reported when the ring is full
  a_full_occ: assert property (@(posedge clk) disable iff (rst)
    (strobe && status == ST_FULL) |-> (occupancy == OCC_W'(DEPTH)))
    else $error("full status with ring not full");

  // the empty status always reports zero items
  a_empty_occ: assert property (@(posedge clk) disable iff (rst)
    (strobe && status == ST_EMPTY) |-> (occupancy == '0 && item_value == '0 && last_of_run))
    else $error("empty status with bad payload");

endmodule

// ----- rtl/dq_ram.sv -----
// ----------------------------------------------------------------------------
// dq_ram
// Element store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module dq_ram import dq_pkg::*; #(
  parameter int DEPTH = 32,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [VAL_W-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [VAL_W-1:0] rd_data
);

  logic [VAL_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ----- rtl/dq_ctrl.sv -----
// ----------------------------------------------------------------------------
// dq_ctrl
// Ring pointers, request decode, read sequencing and the result register.
// ----------------------------------------------------------------------------
module dq_ctrl import dq_pkg::*; #(
  parameter int DEPTH = 32,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  output logic                    busy,
  input  logic [REQ_W-1:0]        req_type,
  input  logic signed [VAL_W-1:0] push_value,
  output logic                    mem_wr_en,
  output logic [AW-1:0]           mem_wr_addr,
  output logic [VAL_W-1:0]        mem_wr_data,
  output logic                    mem_rd_en,
  output logic [AW-1:0]           mem_rd_addr,
  input  logic [VAL_W-1:0]        mem_rd_data,
  output logic                    strobe,
  output logic signed [VAL_W-1:0] item_value,
  output logic                    last_of_run,
  output logic [ST_W-1:0]         status,
  output logic [OCC_W-1:0]        occupancy
);

  localparam int CW = $clog2(DEPTH + 1);
  localparam int SW = AW + 1;

  localparam logic S_IDLE = 1'b0;
  localparam logic S_READ = 1'b1;

  logic          state;
  logic [AW-1:0] front;
  logic [CW-1:0] count;
  logic [AW-1:0] lst_addr;
  logic [CW-1:0] lst_left;
  logic          pend_last;

  logic          accept;
  logic          full;
  logic          empty;
  logic [CW-1:0] count_inc;
  logic [CW-1:0] count_dec;
  logic [AW-1:0] front_inc;
  logic [AW-1:0] front_dec;
  logic [SW-1:0] tail_sum;
  logic [SW-1:0] back_sum;
  logic [AW-1:0] tail_pos;
  logic [AW-1:0] back_pos;

  function automatic logic [OCC_W-1:0] occ_of(input logic [CW-1:0] c);
    logic [OCC_W+CW-1:0] wide;
    wide = {{OCC_W{1'b0}}, c};
    return wide[OCC_W-1:0];
  endfunction

  function automatic logic [AW-1:0] pos_inc(input logic [AW-1:0] a);
    return (a == AW'(DEPTH - 1)) ? '0 : a + 1'b1;
  endfunction

  assign busy      = (state == S_READ);
  assign accept    = start && !busy;
  assign full      = (count == CW'(DEPTH));
  assign empty     = (count == '0);
  assign count_inc = count + 1'b1;
  assign count_dec = count - 1'b1;
  assign front_inc = pos_inc(front);
  assign front_dec = (front == '0) ? AW'(DEPTH - 1) : front - 1'b1;

  // slot after the back element, and the back element itself
  always_comb begin
    tail_sum = SW'(front) + SW'(count);
    back_sum = tail_sum - SW'(1);
    if (tail_sum >= SW'(DEPTH)) begin
      tail_pos = AW'(tail_sum - SW'(DEPTH));
    end else begin
      tail_pos = AW'(tail_sum);
    end
    if (back_sum >= SW'(DEPTH)) begin
      back_pos = AW'(back_sum - SW'(DEPTH));
    end else begin
      back_pos = AW'(back_sum);
    end
  end

  always_comb begin
    mem_wr_en   = 1'b0;
    mem_wr_addr = front_dec;
    mem_wr_data = push_value;
    mem_rd_en   = 1'b0;
    mem_rd_addr = front;
    if (accept) begin
      case (req_type)
        REQ_PUSH_FRONT: begin
          mem_wr_en   = !full;
          mem_wr_addr = front_dec;
        end
        REQ_PUSH_BACK: begin
          mem_wr_en   = !full;
          mem_wr_addr = tail_pos;
        end
        REQ_POP_FRONT: begin
          mem_rd_en   = !empty;
          mem_rd_addr = front;
        end
        REQ_POP_BACK: begin
          mem_rd_en   = !empty;
          mem_rd_addr = back_pos;
        end
        REQ_LIST: begin
          mem_rd_en   = !empty;
          mem_rd_addr = front;
        end
        default: begin
        end
      endcase
    end else if (busy && lst_left != '0) begin
      mem_rd_en   = 1'b1;
      mem_rd_addr = lst_addr;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      front     <= '0;
      count     <= '0;
      lst_left  <= '0;
      pend_last <= 1'b0;
      strobe    <= 1'b0;
    end else begin
      strobe <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (start) begin
            case (req_type) inside
              REQ_PUSH_FRONT, REQ_PUSH_BACK: begin
                strobe      <= 1'b1;
                item_value  <= push_value;
                last_of_run <= 1'b1;
                if (full) begin
                  status    <= ST_FULL;
                  occupancy <= occ_of(count);
                end else begin
                  status    <= ST_DONE;
                  occupancy <= occ_of(count_inc);
                  count     <= count_inc;
                  if (req_type == REQ_PUSH_FRONT) begin
                    front <= front_dec;
                  end
                end
              end
              REQ_POP_FRONT, REQ_POP_BACK: begin
                if (empty) begin
                  strobe      <= 1'b1;
                  item_value  <= '0;
                  last_of_run <= 1'b1;
                  status      <= ST_EMPTY;
                  occupancy   <= '0;
                end else begin
                  count     <= count_dec;
                  state     <= S_READ;
                  lst_left  <= '0;
                  pend_last <= 1'b1;
                  if (req_type == REQ_POP_FRONT) begin
                    front <= front_inc;
                  end
                end
              end
              REQ_LIST: begin
                if (empty) begin
                  strobe      <= 1'b1;
                  item_value  <= '0;
                  last_of_run <= 1'b1;
                  status      <= ST_EMPTY;
                  occupancy   <= '0;
                end else begin
                  state     <= S_READ;
                  lst_addr  <= front_inc;
                  lst_left  <= count_dec;
                  pend_last <= (count == CW'(1));
                end
              end
              default: begin
              end
            endcase
          end
        end
        S_READ: begin
          // read data for the previous cycle's address is now valid
          strobe      <= 1'b1;
          item_value  <= $signed(mem_rd_data);
          last_of_run <= pend_last;
          status      <= ST_DONE;
          occupancy   <= occ_of(count);
          if (lst_left != '0) begin
            lst_addr  <= pos_inc(lst_addr);
            lst_left  <= lst_left - 1'b1;
            pend_last <= (lst_left == CW'(1));
          end else begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
